/* hdl/tfc_pkg.sv */
package tfc_pkg;

    // Palette depth default and the width of the stored colour.
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int COLOR_W           = 24;
    localparam int INDEX_W           = 8;
    localparam int MODE_W            = 3;

    // Format mode codes.
    localparam logic [MODE_W-1:0] MODE_INDEX8  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RGB565  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RGB8    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RGBA8   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PALBAKE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_RGBA8;

    localparam logic [7:0] OPAQUE_ALPHA = 8'h80;

    // Request type codes.
    localparam logic REQ_CONVERT   = 1'b0;
    localparam logic REQ_PAL_WRITE = 1'b1;

    // Palette write port bundle.
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
    } t_pal_wr;

    // Palette read port bundle.
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
    } t_pal_rd;

    // Alpha halving with rounding: (a + 1) >> 1.
    function automatic logic [7:0] f_half_alpha(input logic [7:0] a);
        logic [8:0] s;
        s = {1'b0, a} + 9'd1;
        return s[8:1];
    endfunction

    // RGB565 to RGBA8888, replicating the high bits of each channel.
    function automatic logic [31:0] f_expand_565(input logic [15:0] t);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = t[15:11];
        g6 = t[10:5];
        b5 = t[4:0];
        return {OPAQUE_ALPHA, {b5, b5[4:2]}, {g6, g6[5:4]}, {r5, r5[4:2]}};
    endfunction

endpackage

/* hdl/texel_format_converter_core.sv */
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+---------------------------------------------
// input     | i_in_valid / o_in_ready     | i_req_type, i_texel_bytes, i_palette_index,
//           |                             | i_palette_word
// output    | o_out_valid / i_out_ready   | o_out_word
// config    | i_cfg_we (no wait)          | i_cfg_wdata (format mode)
//
// One transaction is accepted per clock while o_in_ready is high. A convert transaction
// passes through the middle stage and then the output register before it is offered at
// the output. The middle stage covers the registered read of the palette memory.
// Palette writes produce no output transaction and take effect at their acceptance edge.
// Reset is synchronous and active low; it clears the valid flags and sets the format mode
// to rgba8. The palette is undefined until written and is not cleared.
// When the output stalls, the middle stage and the output register both hold; the input
// stays ready as long as one of the two has room.
module texel_format_converter_core #(
    parameter int PALETTE_DEPTH = tfc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_texel_bytes,
    input  logic [7:0]  i_palette_index,
    input  logic [31:0] i_palette_word,
    // Output transactions.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_word,
    // Configuration register write.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);

    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    logic [tfc_pkg::MODE_W-1:0]  r_format_mode;

    // Middle stage: holds everything but the palette colour, which sits in the
    // memory's read data register alongside it.
    logic                        r_s1_valid;
    logic                        r_s1_bake;
    logic                        r_s1_in_range;
    logic [7:0]                  r_s1_alpha;
    logic [31:0]                 r_s1_word;

    logic                        r_out_valid;
    logic [31:0]                 r_out_word;

    logic                        w_in_acc;
    logic                        w_s1_adv;
    logic                        w_is_convert;
    logic                        w_wr_in_range;
    logic                        w_rd_in_range;
    logic [31:0]                 n_s1_word;
    logic [31:0]                 n_out_word;
    logic [tfc_pkg::COLOR_W-1:0] w_pal_data;
    tfc_pkg::t_pal_wr            w_pal_wr;
    tfc_pkg::t_pal_rd            w_pal_rd;

    assign w_s1_adv     = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready   = ~r_s1_valid | ~r_out_valid | i_out_ready;
    assign w_in_acc     = i_in_valid & o_in_ready;
    assign w_is_convert = (i_req_type == tfc_pkg::REQ_CONVERT);

    assign w_wr_in_range = ({1'b0, i_palette_index} < DEPTH_LIM);
    assign w_rd_in_range = ({1'b0, i_texel_bytes[7:0]} < DEPTH_LIM);

    // A palette write lands in memory at its own acceptance edge, and a later bake
    // reads at its own acceptance edge, so reads always observe earlier writes.
    // Both never happen at the same edge because only one transaction is accepted.
    always_comb begin
        w_pal_wr.en    = w_in_acc & ~w_is_convert & w_wr_in_range;
        w_pal_wr.index = i_palette_index;
        w_pal_wr.color = i_palette_word[tfc_pkg::COLOR_W-1:0];
        w_pal_rd.en    = w_in_acc & w_is_convert;
        w_pal_rd.index = i_texel_bytes[7:0];
    end

    tfc_palette_ram #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr      (w_pal_wr),
        .i_rd      (w_pal_rd),
        .o_rd_data (w_pal_data)
    );

    // Format decode for everything that does not need the palette.
    always_comb begin
        unique case (r_format_mode)
            tfc_pkg::MODE_INDEX8: begin
                n_s1_word = {24'd0, i_texel_bytes[7:0]};
            end
            tfc_pkg::MODE_RGB565: begin
                n_s1_word = tfc_pkg::f_expand_565(i_texel_bytes[15:0]);
            end
            tfc_pkg::MODE_RGB8: begin
                n_s1_word = {tfc_pkg::OPAQUE_ALPHA, i_texel_bytes[23:0]};
            end
            tfc_pkg::MODE_PALBAKE: begin
                n_s1_word = 32'd0;
            end
            default: begin
                // Rgba8 and the unused codes.
                n_s1_word = {tfc_pkg::f_half_alpha(i_texel_bytes[31:24]),
                             i_texel_bytes[23:0]};
            end
        endcase
    end

    always_comb begin
        if (r_s1_bake) begin
            n_out_word = {r_s1_alpha,
                          r_s1_in_range ? w_pal_data : {tfc_pkg::COLOR_W{1'b0}}};
        end else begin
            n_out_word = r_s1_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= tfc_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            r_format_mode <= i_cfg_wdata;
        end
    end

    // Control state of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= (w_in_acc & w_is_convert) | (r_s1_valid & ~w_s1_adv);
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_convert) begin
            r_s1_bake     <= (r_format_mode == tfc_pkg::MODE_PALBAKE);
            r_s1_in_range <= w_rd_in_range;
            r_s1_alpha    <= tfc_pkg::f_half_alpha(i_texel_bytes[15:8]);
            r_s1_word     <= n_s1_word;
        end
        if (w_s1_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* hdl/tfc_palette_ram.sv */
module tfc_palette_ram #(
    parameter int DEPTH = tfc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  tfc_pkg::t_pal_wr            i_wr,
    input  tfc_pkg::t_pal_rd            i_rd,
    output logic [tfc_pkg::COLOR_W-1:0] o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [tfc_pkg::COLOR_W-1:0] r_mem [DEPTH];
    logic [tfc_pkg::COLOR_W-1:0] r_rd_data;

    // Synchronous write port; the caller only writes in-range entries.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.index[AW-1:0]] <= i_wr.color;
        end
    end

    // Synchronous read port with registered read data; data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.index[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/tfc_checker.sv */
module tfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_out_word
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // With an empty output register the input can always move.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // No mode produces an alpha above the opaque value.
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word[31:24] <= 8'h80))
        else $error("alpha beyond opaque value");

endmodule

bind texel_format_converter_core tfc_checker u_tfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the texel format converter core.
//
// A short scripted sequence runs first. It covers every format mode, the spare mode
// codes, the channel extremes of rgb565, alpha rounding at both ends, and palette
// bakes with a palette write accepted right before the bake. Random segments follow,
// and each segment runs under one format mode. Every output transaction is compared
// with the oldest word in a queue. The script's written-out word or a behavioral
// converter fills that queue when a convert transaction is accepted.
module tb_top;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int PAL_DEPTH      = tfc_pkg::PALETTE_DEPTH_DEF;
    // A conversion passes the core's middle stage and output register. Palette writes give no output,
    // so after the last result we still allow a few cycles before touching the mode.
    localparam int DRAIN_TAIL     = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 15;
    localparam int SEGMENT_ITEMS  = 30;

    localparam logic REQ_CONVERT   = tfc_pkg::REQ_CONVERT;
    localparam logic REQ_PAL_WRITE = tfc_pkg::REQ_PAL_WRITE;

    // Mode codes above palette bake are spare and convert as rgba8.
    localparam logic [tfc_pkg::MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [tfc_pkg::MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [tfc_pkg::MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
    localparam logic [tfc_pkg::MODE_W-1:0] NO_MODE        = tfc_pkg::MODE_RESET;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // Each random segment runs under one mode. Palette bake gets the most segments
    // because it is the only mode with state.
    localparam logic [tfc_pkg::MODE_W-1:0] SEGMENT_MODES [0:SEGMENTS-1] = '{
        tfc_pkg::MODE_PALBAKE, tfc_pkg::MODE_RGB565, tfc_pkg::MODE_INDEX8,
        tfc_pkg::MODE_RGBA8, MODE_SPARE_HI,
        tfc_pkg::MODE_PALBAKE, tfc_pkg::MODE_RGB8, MODE_SPARE_LO, MODE_SPARE_MID,
        tfc_pkg::MODE_PALBAKE,
        tfc_pkg::MODE_RGB565, tfc_pkg::MODE_PALBAKE, tfc_pkg::MODE_INDEX8,
        tfc_pkg::MODE_RGBA8, tfc_pkg::MODE_PALBAKE
    };

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the scripted sequence. A configuration row carries only a mode. An item
    // row either has its output word written out, or leaves the word to the converter.
    typedef struct packed {
        t_row_kind                   kind;
        logic [tfc_pkg::MODE_W-1:0]  mode;
        logic                        req;
        logic [31:0]                 texel;
        logic [7:0]                  pidx;
        logic [31:0]                 pword;
        logic                        typed;
        logic [31:0]                 word;
    } t_script_row;

    // Clock, reset and the ports of the core. Every input has a known value from time 0.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic        i_req_type      = REQ_CONVERT;
    logic [31:0] i_texel_bytes   = '0;
    logic [7:0]  i_palette_index = '0;
    logic [31:0] i_palette_word  = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [31:0] o_out_word;
    logic        i_cfg_we        = 1'b0;
    logic [2:0]  i_cfg_wdata     = '0;

    // Sideband that travels with each input transaction. It carries a written-out
    // output word from the script to the checker.
    logic        item_typed = PREDICTED;
    logic [31:0] item_word  = '0;

    // State of the behavioral converter. Only the monitor process writes it.
    logic [tfc_pkg::MODE_W-1:0]  mode_shadow = tfc_pkg::MODE_RESET;
    logic [tfc_pkg::COLOR_W-1:0] palette_shadow [PAL_DEPTH];
    logic [31:0]                 expected_words [$];

    // The generator keeps its own list of palette entries that it has written. A bake
    // only ever looks up one of these entries, because an unwritten entry is undefined.
    bit                 index_filled [256];
    logic [7:0]         filled_list [$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int items_sent        = 0;
    int words_checked     = 0;
    int palette_writes    = 0;
    int mismatches        = 0;
    int quiet_cycles      = 0;

    t_script_row directed_rows [32];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    texel_format_converter_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_texel_bytes   (i_texel_bytes),
        .i_palette_index (i_palette_index),
        .i_palette_word  (i_palette_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_word      (o_out_word),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Halving with round-up is the same as (a + 1) >> 1. It cannot overflow: 0xFF gives 0x80.
    function automatic logic [7:0] halved_alpha(input logic [7:0] a);
        return (a >> 1) + {7'b0, a[0]};
    endfunction

    // Behavioral converter. It gives the destination word for one texel under the
    // current mode and palette.
    function automatic logic [31:0] convert_texel(input logic [tfc_pkg::MODE_W-1:0] mode,
                                                  input logic [31:0] t);
        logic [7:0]                  r8;
        logic [7:0]                  g8;
        logic [7:0]                  b8;
        logic [tfc_pkg::COLOR_W-1:0] color;
        // Widening a channel copies its top bits into the low bits of the byte.
        r8 = ({3'b0, t[15:11]} << 3) | ({3'b0, t[15:11]} >> 2);
        g8 = ({2'b0, t[10:5]} << 2) | ({2'b0, t[10:5]} >> 4);
        b8 = ({3'b0, t[4:0]} << 3) | ({3'b0, t[4:0]} >> 2);
        color = (t[7:0] < PAL_DEPTH) ? palette_shadow[t[7:0]] : '0;
        case (mode)
            tfc_pkg::MODE_INDEX8:  return {24'h0, t[7:0]};
            tfc_pkg::MODE_RGB565:  return {tfc_pkg::OPAQUE_ALPHA, b8, g8, r8};
            tfc_pkg::MODE_RGB8:    return {tfc_pkg::OPAQUE_ALPHA, t[23:0]};
            tfc_pkg::MODE_PALBAKE: return {halved_alpha(t[15:8]), color};
            default:               return {halved_alpha(t[31:24]), t[23:0]};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 50) begin
            $display("[%0t] mismatch, %s: expected %08h, got %08h", $time, what, want, got);
        end
    endtask

    // Monitor. It samples both handshakes at the clock edge and sees the values from
    // before the edge, so the order of processes within the time step does not matter.
    // It also updates the model state and runs the watchdog.
    always @(posedge i_clk) begin : monitor
        logic [31:0] want_word;
        logic        active;
        if (!i_rst_n) begin
            mode_shadow  = tfc_pkg::MODE_RESET;
            quiet_cycles = 0;
        end else begin
            active = i_cfg_we;
            if (i_cfg_we) begin
                mode_shadow = i_cfg_wdata;
            end
            // Check the output before queueing a new input. A transaction accepted at this
            // edge cannot come out at the same edge.
            if (o_out_valid && i_out_ready) begin
                active = 1'b1;
                if (expected_words.size() == 0) begin
                    report_mismatch("output transaction with none outstanding", '0,
                                    o_out_word);
                end else begin
                    want_word = expected_words.pop_front();
                    if (o_out_word !== want_word) begin
                        report_mismatch("out_word", want_word, o_out_word);
                    end
                    words_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                active = 1'b1;
                if (i_req_type == REQ_PAL_WRITE) begin
                    // A write beyond the palette depth is dropped. That cannot happen
                    // at depth 256, but the check keeps the model general.
                    if (i_palette_index < PAL_DEPTH) begin
                        palette_shadow[i_palette_index] =
                            i_palette_word[tfc_pkg::COLOR_W-1:0];
                    end
                    palette_writes++;
                end else begin
                    expected_words.push_back(item_typed ? item_word
                                             : convert_texel(mode_shadow, i_texel_bytes));
                end
            end
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d outstanding",
                         $time, WATCHDOG_LIMIT, expected_words.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver. It stalls the output at random, at the rate the current phase sets.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_idle_pct <= receiver_pct;
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Presents one input transaction and waits for it to be accepted. Valid stays high
    // afterward. Only an idle gap or a drain lowers it, and never in the same time step
    // in which it goes high again. Each idle cycle is drawn on its own, so the sender
    // idles in about the set share of its cycles.
    task automatic send_transaction(input logic req, input logic [31:0] texel,
                                    input logic [7:0] pidx, input logic [31:0] pword,
                                    input logic typed, input logic [31:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            idle_sender(1);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_texel_bytes   <= texel;
        i_palette_index <= pidx;
        i_palette_word  <= pword;
        item_typed      <= typed;
        item_word       <= word;
        if (req == REQ_PAL_WRITE && !index_filled[pidx]) begin
            index_filled[pidx] = 1'b1;
            filled_list.push_back(pidx);
        end
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // The sender stops until every outstanding output has arrived. A short tail of
    // DRAIN_TAIL idle cycles follows.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_words.size() != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [tfc_pkg::MODE_W-1:0] mode);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random transaction. About a quarter of them write the palette. A small share
    // of conversions use all-zero or all-one texels. In bake mode the index byte always
    // names a palette entry that has already been written.
    task automatic send_random(input logic [tfc_pkg::MODE_W-1:0] mode);
        logic [31:0] texel;
        int          pick;
        texel = $urandom();
        pick  = $urandom_range(99);
        if (pick < 25) begin
            send_transaction(REQ_PAL_WRITE, texel, 8'($urandom_range(255)), $urandom(),
                             PREDICTED, '0);
        end else begin
            if (pick >= 95) begin
                texel = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
            if (mode == tfc_pkg::MODE_PALBAKE) begin
                texel[7:0] = filled_list[$urandom_range(filled_list.size() - 1)];
            end
            send_transaction(REQ_CONVERT, texel, 8'($urandom_range(255)), $urandom(),
                             PREDICTED, '0);
        end
    endtask

    initial begin : stimulus
        int row;
        int seg;
        int n;
        // Scripted sequence. The first three rows run in the mode that reset selects.
        directed_rows = '{
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0, TYPED, 32'h80FF_FFFF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_0000, 8'h00, 32'h0, TYPED, 32'h0000_0000},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h01AB_CDEF, 8'h00, 32'h0, TYPED, 32'h01AB_CDEF},
            '{ROW_CFG, tfc_pkg::MODE_INDEX8, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0, TYPED, 32'h0000_00FF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h1234_5600, 8'h00, 32'h0, TYPED, 32'h0000_0000},
            '{ROW_CFG, tfc_pkg::MODE_RGB565, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0, TYPED, 32'h80FF_FFFF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFFFF_0000, 8'h00, 32'h0, TYPED, 32'h8000_0000},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_F800, 8'h00, 32'h0, TYPED, 32'h8000_00FF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_07E0, 8'h00, 32'h0, TYPED, 32'h8000_FF00},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_001F, 8'h00, 32'h0, TYPED, 32'h80FF_0000},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h1234_A5A5, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_CFG, tfc_pkg::MODE_RGB8, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0, TYPED, 32'h80FF_FFFF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hAA00_0000, 8'h00, 32'h0, TYPED, 32'h8000_0000},
            // Palette writes give no output. Only the low 24 bits of the word are kept.
            '{ROW_ITEM, NO_MODE, REQ_PAL_WRITE, 32'h0, 8'h00, 32'hFF12_3456, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_PAL_WRITE, 32'h0, 8'hFF, 32'hFFFF_FFFF, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_PAL_WRITE, 32'h0, 8'h80, 32'h0000_0000, PREDICTED, 32'h0},
            '{ROW_CFG, tfc_pkg::MODE_PALBAKE, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_FF00, 8'h00, 32'h0, TYPED, 32'h8012_3456},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFFFF_00FF, 8'h00, 32'h0, TYPED, 32'h00FF_FFFF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_0180, 8'h00, 32'h0, TYPED, 32'h0100_0000},
            // The bake right after this write must see the new entry.
            '{ROW_ITEM, NO_MODE, REQ_PAL_WRITE, 32'h0, 8'h00, 32'h00AB_CDEF, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0000_0000, 8'h00, 32'h0, TYPED, 32'h00AB_CDEF},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h5A5A_3C80, 8'h00, 32'h0, PREDICTED, 32'h0},
            // The spare mode codes behave like rgba8.
            '{ROW_CFG, MODE_SPARE_HI, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'hFEFF_FFFF, 8'h00, 32'h0, TYPED, 32'h7FFF_FFFF},
            '{ROW_CFG, MODE_SPARE_LO, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h8000_0000, 8'h00, 32'h0, TYPED, 32'h4000_0000},
            '{ROW_CFG, MODE_SPARE_MID, REQ_CONVERT, 32'h0, 8'h00, 32'h0, PREDICTED, 32'h0},
            '{ROW_ITEM, NO_MODE, REQ_CONVERT, 32'h0300_0001, 8'h00, 32'h0, TYPED, 32'h0200_0001}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First idling phase: the sender is mostly busy and the receiver mostly stalls.
        set_idling(29, 64);
        for (row = 0; row < $size(directed_rows); row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                write_mode(directed_rows[row].mode);
            end else begin
                send_transaction(directed_rows[row].req, directed_rows[row].texel,
                                 directed_rows[row].pidx, directed_rows[row].pword,
                                 directed_rows[row].typed, directed_rows[row].word);
            end
        end

        // Random segments. The idling swaps after one third of them and stops after two
        // thirds. In some segments the sender also stops halfway until all outputs are in.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                set_idling(64, 29);
            end else if (seg == 2 * SEGMENTS / 3) begin
                set_idling(0, 0);
            end
            write_mode(SEGMENT_MODES[seg]);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                if (n == SEGMENT_ITEMS / 2 && seg % 3 == 1) begin
                    drain_results();
                end
                send_random(SEGMENT_MODES[seg]);
            end
        end

        drain_results();
        $display("Covered all eight mode codes with %0d input transactions (%0d palette writes).",
                 items_sent, palette_writes);
        $display("Compared %0d output words under three idling patterns; %0d mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
